[sv/pps_pkg.sv]
`timescale 1ns / 1ps
package pps_pkg;
    localparam int MAX_VIEWPORT = 4096;
    localparam int DIM_W = 13;
    localparam int CLIP_W = 40;
    localparam int NUM_W = CLIP_W + 1 + DIM_W;
    localparam int QUO_W = 15;
    localparam int DIV_W = CLIP_W + 1;

    typedef enum logic [2:0] {
        REG_PACK0 = 3'd0, REG_PACK1 = 3'd1, REG_PACK2 = 3'd2, REG_PACK3 = 3'd3,
        REG_PACK4 = 3'd4, REG_PACK5 = 3'd5, REG_WIDTH = 3'd6, REG_HEIGHT = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic                     live;
        logic signed [NUM_W-1:0]  rem_x;
        logic signed [NUM_W-1:0]  rem_y;
        logic        [QUO_W-1:0]  q_x;
        logic        [QUO_W-1:0]  q_y;
        logic                     neg_x;
        logic                     neg_y;
        logic        [DIV_W-1:0]  den;
        logic        [DIM_W-1:0]  w;
        logic        [DIM_W-1:0]  h;
    } div_t;
endpackage

[sv/point_project_to_screen.sv]
`timescale 1ns / 1ps
// channel | dir | tdata (low bit up)                          | tuser
// s_axis  | in  | pos_x[31:0], pos_y[63:32], pos_z[95:64]        | -
// m_axis  | out | screen_x[12:0], screen_y[25:13] (pad to 32b)   | visible
// One item per cycle while the output is not stalled; the restoring
// divider retires one quotient bit per stage for both coordinates.
// aresetn is synchronous; clears valid bits and the matrix, sets 640x480.
// A stall on m_tready freezes the whole pipeline; s_tready follows it.
module point_project_to_screen import pps_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // pos_x, pos_y, pos_z
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,   // screen_x, screen_y, 6'b0
    output logic         m_tuser,   // visible
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);
    localparam int NS = QUO_W;

    logic [62:0] pack_reg [5];
    logic [DIM_W-1:0] vw_reg, vh_reg;
    logic wr;
    reg_idx_t widx;
    assign pready = 1'b1;
    assign wr = psel & penable & pwrite;
    assign widx = reg_idx_t'(paddr[5:3]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 5; i++) pack_reg[i] <= '0;
            vw_reg <= DIM_W'(640);
            vh_reg <= DIM_W'(480);
        end else if (wr) begin
            unique case (widx)
                REG_PACK0, REG_PACK1, REG_PACK2, REG_PACK3, REG_PACK4:
                    pack_reg[widx] <= pwdata[62:0];
                REG_PACK5:  pack_reg[4] <= pack_reg[4];
                REG_WIDTH:  vw_reg <= pwdata[DIM_W-1:0];
                REG_HEIGHT: vh_reg <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end
    logic [20:0] m33_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) m33_reg <= '0;
        else if (wr && widx == REG_PACK5) m33_reg <= pwdata[20:0];
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx_t'(paddr[5:3]))
            REG_PACK0, REG_PACK1, REG_PACK2, REG_PACK3, REG_PACK4:
                prdata = {1'b0, pack_reg[paddr[5:3]]};
            REG_PACK5:  prdata = {43'd0, m33_reg};
            REG_WIDTH:  prdata = {51'd0, vw_reg};
            REG_HEIGHT: prdata = {51'd0, vh_reg};
            default: ;
        endcase
    end

    logic signed [20:0] m [16];
    always_comb begin
        for (int k = 0; k < 15; k++) m[k] = pack_reg[k/3][(k%3)*21 +: 21];
        m[15] = m33_reg;
    end

    logic adv;
    assign adv = m_tready | ~m_tvalid;
    assign s_tready = adv;

    // stage 1: products
    logic v1_reg;
    logic signed [52:0] p_reg [9];
    logic signed [20:0] k_reg [3];
    logic [DIM_W-1:0] w1_reg, h1_reg;
    logic signed [31:0] px, py, pz;
    assign px = s_tdata[31:0];
    assign py = s_tdata[63:32];
    assign pz = s_tdata[95:64];
    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (adv) v1_reg <= s_tvalid;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int r = 0; r < 3; r++) begin
                automatic int rr = (r == 2) ? 3 : r;
                p_reg[3*r]   <= m[4*rr]   * px;
                p_reg[3*r+1] <= m[4*rr+1] * py;
                p_reg[3*r+2] <= m[4*rr+2] * pz;
                k_reg[r]     <= m[4*rr+3];
            end
            w1_reg <= (vw_reg > DIM_W'(MAX_VIEWPORT)) ? DIM_W'(MAX_VIEWPORT) : vw_reg;
            h1_reg <= (vh_reg > DIM_W'(MAX_VIEWPORT)) ? DIM_W'(MAX_VIEWPORT) : vh_reg;
        end
    end

    // stage 2: sums, Q.16 floored to integer
    logic v2_reg;
    logic signed [CLIP_W-1:0] c_reg [3];
    logic [DIM_W-1:0] w2_reg, h2_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (adv) v2_reg <= v1_reg;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int r = 0; r < 3; r++) begin
                automatic logic signed [56:0] s;
                s = 57'(p_reg[3*r]) + 57'(p_reg[3*r+1]) + 57'(p_reg[3*r+2])
                    + ({{36{k_reg[r][20]}}, k_reg[r]} <<< 16);
                c_reg[r] <= CLIP_W'(s >>> 16);
            end
            w2_reg <= w1_reg;
            h2_reg <= h1_reg;
        end
    end

    // stage 3: numerators (two multiplies by the viewport size)
    logic v3_reg;
    logic signed [NUM_W-1:0] nx_reg, ny_reg;
    logic [DIV_W-1:0] d3_reg;
    logic pos3_reg;
    logic [DIM_W-1:0] w3_reg, h3_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v3_reg <= 1'b0;
        else if (adv) v3_reg <= v2_reg;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            nx_reg <= (NUM_W'(c_reg[0]) + NUM_W'(c_reg[2])) * $signed({1'b0, w2_reg});
            ny_reg <= (NUM_W'(c_reg[2]) - NUM_W'(c_reg[1])) * $signed({1'b0, h2_reg});
            d3_reg <= {c_reg[2][CLIP_W-1:0], 1'b0};
            pos3_reg <= (c_reg[2] > 0);
            w3_reg <= w2_reg;
            h3_reg <= h2_reg;
        end
    end

    // stage 4: magnitudes; quotients beyond 2^QUO_W are invisible anyway
    logic v4_reg;
    logic [NUM_W-1:0] ax_reg, ay_reg;
    div_t d4_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v4_reg <= 1'b0;
        else if (adv) v4_reg <= v3_reg;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            ax_reg <= nx_reg[NUM_W-1] ? NUM_W'(-nx_reg) : nx_reg;
            ay_reg <= ny_reg[NUM_W-1] ? NUM_W'(-ny_reg) : ny_reg;
            d4_reg.live  <= pos3_reg;
            d4_reg.neg_x <= nx_reg[NUM_W-1];
            d4_reg.neg_y <= ny_reg[NUM_W-1];
            d4_reg.den   <= d3_reg;
            d4_reg.w     <= w3_reg;
            d4_reg.h     <= h3_reg;
            d4_reg.q_x   <= '0;
            d4_reg.q_y   <= '0;
            d4_reg.rem_x <= '0;
            d4_reg.rem_y <= '0;
        end
    end

    // restoring divider: one quotient bit per stage for both coordinates
    logic v5_reg;
    logic vs_reg [NS];
    div_t ds_reg [NS];
    logic ovx_reg [NS], ovy_reg [NS];
    logic [NUM_W-1:0] nxs_reg [NS], nys_reg [NS];
    for (genvar g = 0; g < NS; g++) begin : g_div
        logic vin, ox_in, oy_in, bx, by;
        div_t din, ds_next;
        logic [NUM_W-1:0] nx_in, ny_in, dsh;
        if (g == 0) begin : g_head
            // overflow check: quotient >= 2^QUO_W -> out of bounds
            assign vin   = v4_reg;
            assign din   = d4_reg;
            assign nx_in = ax_reg;
            assign ny_in = ay_reg;
            assign ox_in = (ax_reg >= (NUM_W'(d4_reg.den) << NS));
            assign oy_in = (ay_reg >= (NUM_W'(d4_reg.den) << NS));
        end else begin : g_body
            assign vin   = vs_reg[g-1];
            assign din   = ds_reg[g-1];
            assign nx_in = nxs_reg[g-1];
            assign ny_in = nys_reg[g-1];
            assign ox_in = ovx_reg[g-1];
            assign oy_in = ovy_reg[g-1];
        end
        assign dsh = NUM_W'(din.den) << (NS - 1 - g);
        assign bx = (nx_in >= dsh);
        assign by = (ny_in >= dsh);
        always_comb begin
            ds_next = din;
            ds_next.q_x[NS-1-g] = bx;
            ds_next.q_y[NS-1-g] = by;
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) vs_reg[g] <= 1'b0;
            else if (adv) vs_reg[g] <= vin;
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                ds_reg[g]  <= ds_next;
                ovx_reg[g] <= ox_in;
                ovy_reg[g] <= oy_in;
                nxs_reg[g] <= bx ? nx_in - dsh : nx_in;
                nys_reg[g] <= by ? ny_in - dsh : ny_in;
            end
        end
    end
    assign v5_reg = vs_reg[NS-1];

    // output stage: sign and bounds
    div_t df;
    logic okx, oky, vis;
    assign df = ds_reg[NS-1];
    assign okx = !ovx_reg[NS-1] && (df.q_x == '0 || (!df.neg_x && df.q_x <= QUO_W'(df.w)));
    assign oky = !ovy_reg[NS-1] && (df.q_y == '0 || (!df.neg_y && df.q_y <= QUO_W'(df.h)));
    assign vis = df.live && okx && oky;

    logic mv_reg, mu_reg;
    logic [DIM_W-1:0] sx_reg, sy_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) mv_reg <= 1'b0;
        else if (adv) mv_reg <= v5_reg;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            mu_reg <= vis;
            sx_reg <= vis ? df.q_x[DIM_W-1:0] : '0;
            sy_reg <= vis ? df.q_y[DIM_W-1:0] : '0;
        end
    end
    assign m_tvalid = mv_reg;
    assign m_tuser  = mu_reg;
    assign m_tdata  = {6'b0, sy_reg, sx_reg};

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");
    a_zero_hidden: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("hidden point has nonzero coordinates");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (m_tready || !m_tvalid))
        else $error("ready mismatch");
endmodule
